// File: design/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros
// shared helpers for the concurrent checks of the project
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check with reset masking
`define CHK_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("check failed");

// check that also runs during reset
`define CHK_ASSERT_ALWAYS(name, clk, prop) \
    name: assert property (@(posedge clk) prop) \
        else $error("check failed");

`endif

// File: design/rpnh_pkg.sv
// ---------------------------------------------------------------------------
// rpnh_pkg
// shared types and constants of the ray to wall polyline nearest hit block
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rpnh_pkg;

    localparam int MAX_POINTS_DEF = 1024;

    localparam int VEC_W  = 33;
    localparam int OPD_W  = 34;
    localparam int ACC_W  = 68;
    localparam int DEN_W  = 51;
    localparam int Q_W    = 31;

    localparam logic [1:0] REG_LEFT_COUNT  = 2'd0;
    localparam logic [1:0] REG_RIGHT_COUNT = 2'd1;
    localparam logic [1:0] REG_EPSILON     = 2'd2;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_CAST = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WALL,
        ST_RDA,
        ST_RDA_W,
        ST_RDB,
        ST_RDB_W,
        ST_VEC,
        ST_MUL,
        ST_NORM,
        ST_TEST,
        ST_DIV,
        ST_UPD,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD,
        ACC_SUB
    } acc_op_t;

    typedef struct packed {
        logic    mul_en;
        acc_op_t acc_op;
    } mac_ctrl_t;

    typedef struct packed {
        logic load;
        logic step;
    } div_ctrl_t;

endpackage

`default_nettype wire

// File: design/rpnh_mem.sv
// ---------------------------------------------------------------------------
// rpnh_mem
// wall point store, one write port and one registered read port
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rpnh_mem #(
    parameter int DEPTH = 2048,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [63:0]   wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [63:0]   rd_data
);

    logic [63:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: design/rpnh_mac.sv
// ---------------------------------------------------------------------------
// rpnh_mac
// shared signed multiplier with a product register and an accumulator
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rpnh_mac (
    input  wire logic                                 clk,
    input  wire rpnh_pkg::mac_ctrl_t                  ctrl,
    input  wire logic signed [rpnh_pkg::OPD_W-1:0]    op_a,
    input  wire logic signed [rpnh_pkg::OPD_W-1:0]    op_b,
    output logic signed      [rpnh_pkg::ACC_W-1:0]    acc
);
    import rpnh_pkg::*;

    logic signed [ACC_W-1:0] prod_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg <= op_a * op_b;
        end
        acc_reg <= acc_next;
    end

    always_comb
    begin
        case (ctrl.acc_op)
            ACC_LOAD: acc_next = prod_reg;
            ACC_ADD:  acc_next = acc_reg + prod_reg;
            ACC_SUB:  acc_next = acc_reg - prod_reg;
            default:  acc_next = acc_reg;
        endcase
    end

    assign acc = acc_reg;

endmodule

`default_nettype wire

// File: design/rpnh_div.sv
// ---------------------------------------------------------------------------
// rpnh_div
// restoring divider, one quotient bit per cycle while step is set
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rpnh_div (
    input  wire logic                          clk,
    input  wire rpnh_pkg::div_ctrl_t           ctrl,
    input  wire logic [rpnh_pkg::DEN_W-1:0]    rem_init,
    input  wire logic [rpnh_pkg::Q_W-1:0]      bits_init,
    input  wire logic [rpnh_pkg::DEN_W-1:0]    den,
    output logic      [rpnh_pkg::Q_W-1:0]      quot
);
    import rpnh_pkg::*;

    logic [DEN_W-1:0] rem_reg;
    logic [Q_W-1:0]   sh_reg;
    logic [Q_W-1:0]   q_reg;
    logic [DEN_W:0]   rem_sh;
    logic             ge;
    logic [DEN_W:0]   rem_sub;

    assign rem_sh  = {rem_reg, sh_reg[Q_W-1]};
    assign ge      = rem_sh >= {1'b0, den};
    assign rem_sub = rem_sh - {1'b0, den};

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            rem_reg <= rem_init;
            sh_reg  <= bits_init;
            q_reg   <= '0;
        end
        else if (ctrl.step)
        begin
            rem_reg <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            sh_reg  <= {sh_reg[Q_W-2:0], 1'b0};
            q_reg   <= {q_reg[Q_W-2:0], ge};
        end
    end

    assign quot = q_reg;

endmodule

`default_nettype wire

// File: design/ray_polyline_nearest_hit.sv
// ---------------------------------------------------------------------------
// ray_polyline_nearest_hit
// nearest hit of a ray against the stored left and right wall polylines
// ---------------------------------------------------------------------------
// A load word writes one wall point when its index is below MAX_POINTS. A cast
// word walks every segment of the left wall, then the right wall, with one
// shared multiplier (six products per segment) and a one-bit-per-cycle divider
// (31 steps). A segment rejected early skips the divider. The block takes no
// word while a cast runs. No clearing pass follows reset.
`timescale 1ns / 1ps
`default_nettype none

module ray_polyline_nearest_hit #(
    parameter int MAX_POINTS = rpnh_pkg::MAX_POINTS_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // point_index, point_x, point_y, origin_x, origin_y, dir_x, dir_y,
    // max_distance, zero pad
    input  wire logic [207:0] s_tdata,
    // op, wall_select
    input  wire logic [1:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // hit_distance, zero pad
    output logic      [31:0]  m_tdata,
    // hit
    output logic      [0:0]   m_tuser,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [3:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic      [31:0]  prdata,
    output logic              pready
);
    import rpnh_pkg::*;

    localparam int DEPTH = 2 * MAX_POINTS;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(MAX_POINTS + 1);

    // input fields
    logic                    in_op;
    logic                    in_wall;
    logic [9:0]              in_index;
    logic [31:0]             in_px;
    logic [31:0]             in_py;
    logic [31:0]             in_ox;
    logic [31:0]             in_oy;
    logic [15:0]             in_dx;
    logic [15:0]             in_dy;
    logic [30:0]             in_maxd;

    assign in_op    = s_tuser[0];
    assign in_wall  = s_tuser[1];
    assign in_index = s_tdata[9:0];
    assign in_px    = s_tdata[41:10];
    assign in_py    = s_tdata[73:42];
    assign in_ox    = s_tdata[105:74];
    assign in_oy    = s_tdata[137:106];
    assign in_dx    = s_tdata[153:138];
    assign in_dy    = s_tdata[169:154];
    assign in_maxd  = s_tdata[200:170];

    // configuration
    logic [10:0] left_count_reg;
    logic [10:0] right_count_reg;
    logic [15:0] epsilon_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_count_reg  <= '0;
            right_count_reg <= '0;
            epsilon_reg     <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_LEFT_COUNT:  left_count_reg  <= pwdata[10:0];
                REG_RIGHT_COUNT: right_count_reg <= pwdata[10:0];
                REG_EPSILON:     epsilon_reg     <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_LEFT_COUNT:  prdata = {21'd0, left_count_reg};
            REG_RIGHT_COUNT: prdata = {21'd0, right_count_reg};
            REG_EPSILON:     prdata = {16'd0, epsilon_reg};
            default:         prdata = '0;
        endcase
    end

    // state
    state_t state_reg, state_next;

    logic                    s_acc;
    logic                    m_acc;
    logic                    m_valid_reg;
    logic                    out_hit_reg;
    logic [30:0]             out_dist_reg;
    logic                    wall_reg;
    logic [CW-1:0]           idx_reg;
    logic [4:0]              step_reg;
    logic [30:0]             best_reg;
    logic                    any_hit_reg;
    logic                    cand_reg;

    logic signed [31:0]      ox_reg, oy_reg;
    logic signed [16:0]      px_reg, py_reg;
    logic signed [31:0]      ax_reg, ay_reg, bx_reg, by_reg;
    logic signed [VEC_W-1:0] v1x_reg, v1y_reg, v2x_reg, v2y_reg;
    logic signed [DEN_W-1:0] d_reg, t_reg, tn_reg;
    logic signed [ACC_W-1:0] num_reg, numn_reg;
    logic [DEN_W-1:0]        den_reg;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign m_acc    = m_valid_reg && m_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, out_dist_reg};
    assign m_tuser  = out_hit_reg;

    // wall store
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [63:0]   rd_data;

    assign wr_en   = s_acc && (in_op == OP_LOAD) && (32'(in_index) < MAX_POINTS);
    assign wr_addr = AW'(32'(in_wall) * MAX_POINTS + 32'(in_index));
    assign rd_en   = (state_reg == ST_RDA) || (state_reg == ST_RDB);
    assign rd_addr = AW'(32'(wall_reg) * MAX_POINTS + 32'(idx_reg));

    rpnh_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data ({in_py, in_px}),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // point count of the current wall, clamped
    logic [10:0]   lim_raw;
    logic [CW-1:0] lim;
    logic [CW-1:0] idx_inc;

    assign lim_raw = wall_reg ? right_count_reg : left_count_reg;
    assign lim     = (32'(lim_raw) > MAX_POINTS) ? CW'(MAX_POINTS) : CW'(lim_raw);
    assign idx_inc = idx_reg + CW'(1);

    // shared multiplier
    mac_ctrl_t               mac_ctrl;
    logic signed [OPD_W-1:0] op_a, op_b;
    logic signed [ACC_W-1:0] acc;

    always_comb
    begin
        mac_ctrl.mul_en = (state_reg == ST_MUL) && (step_reg < 5'd6);
        mac_ctrl.acc_op = ACC_HOLD;
        op_a = OPD_W'(v2x_reg);
        op_b = OPD_W'(px_reg);
        case (step_reg)
            5'd1:
            begin
                op_a = OPD_W'(v2y_reg);
                op_b = OPD_W'(py_reg);
            end
            5'd2:
            begin
                op_a = OPD_W'(v1x_reg);
                op_b = OPD_W'(px_reg);
            end
            5'd3:
            begin
                op_a = OPD_W'(v1y_reg);
                op_b = OPD_W'(py_reg);
            end
            5'd4:
            begin
                op_a = OPD_W'(v2x_reg);
                op_b = OPD_W'(v1y_reg);
            end
            5'd5:
            begin
                op_a = OPD_W'(v2y_reg);
                op_b = OPD_W'(v1x_reg);
            end
            default: ;
        endcase
        if (state_reg == ST_MUL)
        begin
            case (step_reg)
                5'd1, 5'd3, 5'd5: mac_ctrl.acc_op = ACC_LOAD;
                5'd2, 5'd4:       mac_ctrl.acc_op = ACC_ADD;
                5'd6:             mac_ctrl.acc_op = ACC_SUB;
                default:          mac_ctrl.acc_op = ACC_HOLD;
            endcase
        end
    end

    rpnh_mac u_mac (
        .clk  (clk),
        .ctrl (mac_ctrl),
        .op_a (op_a),
        .op_b (op_b),
        .acc  (acc)
    );

    // divider
    div_ctrl_t        div_ctrl;
    logic [Q_W-1:0]   quot;
    logic             reject;

    assign reject = (den_reg <= DEN_W'(epsilon_reg))
                 || tn_reg[DEN_W-1]
                 || ($unsigned(tn_reg) > den_reg)
                 || numn_reg[ACC_W-1]
                 || (numn_reg == '0)
                 || (numn_reg[ACC_W-1:17] >= den_reg);

    always_comb
    begin
        div_ctrl.load = (state_reg == ST_TEST) && !reject;
        div_ctrl.step = (state_reg == ST_DIV);
    end

    rpnh_div u_div (
        .clk       (clk),
        .ctrl      (div_ctrl),
        .rem_init  (numn_reg[ACC_W-1:17]),
        .bits_init ({numn_reg[16:0], 14'd0}),
        .den       (den_reg),
        .quot      (quot)
    );

    logic take;
    assign take = cand_reg && (quot != '0) && (quot <= best_reg);

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_DONE && (!m_valid_reg || m_tready))
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_acc)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_acc && in_op == OP_CAST)
                begin
                    state_next = ST_WALL;
                end
            end
            ST_WALL:
            begin
                if (lim >= CW'(2))
                begin
                    state_next = ST_RDA;
                end
                else if (wall_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_RDA:   state_next = ST_RDA_W;
            ST_RDA_W: state_next = ST_RDB;
            ST_RDB:   state_next = ST_RDB_W;
            ST_RDB_W: state_next = ST_VEC;
            ST_VEC:   state_next = ST_MUL;
            ST_MUL:
            begin
                if (step_reg == 5'd7)
                begin
                    state_next = ST_NORM;
                end
            end
            ST_NORM:  state_next = ST_TEST;
            ST_TEST:  state_next = reject ? ST_UPD : ST_DIV;
            ST_DIV:
            begin
                if (step_reg == 5'(Q_W - 1))
                begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD:
            begin
                if (idx_inc < lim)
                begin
                    state_next = ST_RDB;
                end
                else if (!wall_reg)
                begin
                    state_next = ST_WALL;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // working registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wall_reg    <= 1'b0;
            idx_reg     <= '0;
            step_reg    <= '0;
            best_reg    <= '0;
            any_hit_reg <= 1'b0;
            cand_reg    <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (s_acc && in_op == OP_CAST)
                    begin
                        wall_reg    <= 1'b0;
                        best_reg    <= in_maxd;
                        any_hit_reg <= 1'b0;
                    end
                end
                ST_WALL:
                begin
                    idx_reg <= '0;
                    if (lim < CW'(2) && !wall_reg)
                    begin
                        wall_reg <= 1'b1;
                    end
                end
                ST_RDA_W: idx_reg  <= CW'(1);
                ST_VEC:   step_reg <= '0;
                ST_MUL:   step_reg <= (step_reg == 5'd7) ? 5'd0 : step_reg + 5'd1;
                ST_TEST:
                begin
                    cand_reg <= !reject;
                    step_reg <= '0;
                end
                ST_DIV:   step_reg <= step_reg + 5'd1;
                ST_UPD:
                begin
                    if (take)
                    begin
                        best_reg    <= quot;
                        any_hit_reg <= 1'b1;
                    end
                    cand_reg <= 1'b0;
                    if (idx_inc < lim)
                    begin
                        idx_reg <= idx_inc;
                    end
                    else if (!wall_reg)
                    begin
                        wall_reg <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath payload
    always_ff @(posedge clk)
    begin
        if (s_acc && in_op == OP_CAST)
        begin
            ox_reg <= in_ox;
            oy_reg <= in_oy;
            px_reg <= -{in_dy[15], in_dy};
            py_reg <= {in_dx[15], in_dx};
        end
        if (state_reg == ST_RDA_W)
        begin
            ax_reg <= rd_data[31:0];
            ay_reg <= rd_data[63:32];
        end
        if (state_reg == ST_RDB_W)
        begin
            bx_reg <= rd_data[31:0];
            by_reg <= rd_data[63:32];
        end
        if (state_reg == ST_VEC)
        begin
            v1x_reg <= {ox_reg[31], ox_reg} - {ax_reg[31], ax_reg};
            v1y_reg <= {oy_reg[31], oy_reg} - {ay_reg[31], ay_reg};
            v2x_reg <= {bx_reg[31], bx_reg} - {ax_reg[31], ax_reg};
            v2y_reg <= {by_reg[31], by_reg} - {ay_reg[31], ay_reg};
        end
        if (state_reg == ST_MUL)
        begin
            if (step_reg == 5'd3)
            begin
                d_reg <= acc[DEN_W-1:0];
            end
            if (step_reg == 5'd5)
            begin
                t_reg <= acc[DEN_W-1:0];
            end
            if (step_reg == 5'd7)
            begin
                num_reg <= acc;
            end
        end
        if (state_reg == ST_NORM)
        begin
            den_reg  <= d_reg[DEN_W-1] ? DEN_W'(-d_reg) : DEN_W'(d_reg);
            tn_reg   <= d_reg[DEN_W-1] ? -t_reg : t_reg;
            numn_reg <= d_reg[DEN_W-1] ? -num_reg : num_reg;
        end
        if (state_reg == ST_UPD)
        begin
            ax_reg <= bx_reg;
            ay_reg <= by_reg;
        end
        if (state_reg == ST_DONE && (!m_valid_reg || m_tready))
        begin
            out_hit_reg  <= any_hit_reg;
            out_dist_reg <= best_reg;
        end
    end

endmodule

`default_nettype wire

// File: design/rpnh_checker.sv
// ---------------------------------------------------------------------------
// rpnh_checker
// port level checks of the ray to wall polyline nearest hit block
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module rpnh_checker (
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         s_tvalid,
    input wire logic         s_tready,
    input wire logic [1:0]   s_tuser,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [31:0]  m_tdata
);
    import rpnh_pkg::*;

    // a cast word keeps the block busy
    `CHK_ASSERT(a_cast_busy, clk, rst_n, s_tvalid && s_tready && s_tuser[0] == OP_CAST |=> !s_tready)

    // a load word leaves the block ready in the next cycle
    `CHK_ASSERT(a_load_quick, clk, rst_n, s_tvalid && s_tready && s_tuser[0] == OP_LOAD |=> s_tready)

    // a stalled result word holds
    `CHK_ASSERT(a_out_hold, clk, rst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))

    // no result word during reset
    `CHK_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |-> !m_tvalid)

endmodule

bind ray_polyline_nearest_hit rpnh_checker u_rpnh_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
